// File: hw/rtl/dspg_pkg.sv
`timescale 1ns / 1ps

package dspg_pkg;

   // number of motors served by one tick (1 to 4, the reach of the index field)
   localparam int MOTOR_COUNT = 4;

   // fixed field widths
   localparam int INDEX_W = 2;
   localparam int DATA_W  = 32;
   localparam int PHASE_W = DATA_W + 1;

   // width of an internal motor select
   localparam int SEL_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

   // width wide enough to hold the motor count, a select and an index field
   localparam int CMP_W = ($clog2(MOTOR_COUNT + 1) > INDEX_W) ?
                          $clog2(MOTOR_COUNT + 1) : INDEX_W + 1;

   localparam logic [SEL_W-1:0] LAST_MOTOR   = SEL_W'(MOTOR_COUNT - 1);
   localparam logic [CMP_W-1:0] MOTOR_LIMIT  = CMP_W'(MOTOR_COUNT);

   localparam logic [DATA_W-1:0] THRESHOLD_RESET = 32'h8000_0000;

   // item modes
   localparam logic MODE_TICK = 1'b0;
   localparam logic MODE_LOAD = 1'b1;

   // result status codes
   localparam logic STATUS_CLEAR   = 1'b0;
   localparam logic STATUS_REFUSED = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic             capture;    // take in the request payload
      logic             vel_step;   // velocity += acceleration for one motor
      logic             acc_step;   // accumulate, step, present result
      logic             load_step;  // load one motor, present result
      logic [SEL_W-1:0] motor;      // motor visited by the tick
      logic             last;       // final motor of the tick
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;   // result register can take a new result this cycle
   } dp_status_type;

   // index field to store select
   function automatic logic [SEL_W-1:0] index_to_sel(input logic [INDEX_W-1:0] idx);
      logic [CMP_W-1:0] wide;
      wide = CMP_W'(idx);
      return wide[SEL_W-1:0];
   endfunction

   // store select to motor number field
   function automatic logic [INDEX_W-1:0] sel_to_number(input logic [SEL_W-1:0] sel);
      logic [CMP_W-1:0] wide;
      wide = CMP_W'(sel);
      return wide[INDEX_W-1:0];
   endfunction

endpackage

// File: hw/rtl/dspg_ctrl.sv
`timescale 1ns / 1ps

module dspg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_mode,
   input  dspg_pkg::dp_status_type dp_status,
   output dspg_pkg::ctrl_cmd_type  cmd,
   output logic                   idle
);
   import dspg_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_VEL  = 2'd2;
   localparam logic [1:0] ST_ACC  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [SEL_W-1:0] motor_ff, motor_in;

   always_comb begin
      state_in      = state_ff;
      motor_in      = motor_ff;
      cmd           = '0;
      cmd.motor     = motor_ff;
      cmd.last      = (motor_ff == LAST_MOTOR);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               motor_in    = '0;
               state_in    = (req_mode == MODE_LOAD) ? ST_LOAD : ST_VEL;
            end
         end
         ST_LOAD: begin
            if (dp_status.out_free) begin
               cmd.load_step = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_VEL: begin
            cmd.vel_step = 1'b1;
            state_in     = ST_ACC;
         end
         ST_ACC: begin
            if (dp_status.out_free) begin
               cmd.acc_step = 1'b1;
               if (motor_ff == LAST_MOTOR) begin
                  state_in = ST_IDLE;
               end else begin
                  motor_in = motor_ff + SEL_W'(1);
                  state_in = ST_VEL;
               end
            end
         end
      endcase
   end

   assign idle = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         motor_ff <= '0;
      end else begin
         state_ff <= state_in;
         motor_ff <= motor_in;
      end
   end

endmodule

// File: hw/rtl/dspg_datapath.sv
`timescale 1ns / 1ps

module dspg_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  dspg_pkg::ctrl_cmd_type              cmd,
   output dspg_pkg::dp_status_type             dp_status,
   // request payload
   input  logic                                req_mode,
   input  logic [dspg_pkg::INDEX_W-1:0]        req_motor_index,
   input  logic [dspg_pkg::DATA_W-1:0]         req_velocity_value,
   input  logic [dspg_pkg::DATA_W-1:0]         req_accel_value,
   input  logic signed [dspg_pkg::DATA_W-1:0]  req_position_value,
   input  logic                                req_direction_value,
   // threshold register write
   input  logic                                csr_write,
   input  logic [dspg_pkg::DATA_W-1:0]         csr_data,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dspg_pkg::INDEX_W-1:0]        rsp_motor_number,
   output logic                                rsp_stepped,
   output logic                                rsp_direction_out,
   output logic signed [dspg_pkg::DATA_W-1:0]  rsp_position_out,
   output logic [dspg_pkg::DATA_W-1:0]         rsp_velocity_out,
   output logic                                rsp_status,
   output logic                                rsp_last
);
   import dspg_pkg::*;

   // per-motor state
   logic [DATA_W-1:0]  vel_store_ff   [MOTOR_COUNT];
   logic [DATA_W-1:0]  accel_store_ff [MOTOR_COUNT];
   logic [PHASE_W-1:0] phase_store_ff [MOTOR_COUNT];
   logic [DATA_W-1:0]  pos_store_ff   [MOTOR_COUNT];
   logic               dir_store_ff   [MOTOR_COUNT];

   logic [DATA_W-1:0]  threshold_ff;

   // captured request
   logic               mode_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic [DATA_W-1:0]  ld_vel_ff, ld_accel_ff, ld_pos_ff;
   logic               ld_dir_ff;

   // velocity carried from the velocity step to the accumulator step
   logic [DATA_W-1:0]  vel_ff, vel_in;

   // result register
   logic               rsp_valid_ff;
   logic [INDEX_W-1:0] rsp_motor_ff, rsp_motor_in;
   logic               rsp_stepped_ff, rsp_stepped_in;
   logic               rsp_dir_ff, rsp_dir_in;
   logic [DATA_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [DATA_W-1:0]  rsp_vel_ff, rsp_vel_in;
   logic               rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [SEL_W-1:0]   load_sel, addr;
   logic               in_range;

   logic [DATA_W:0]    vel_sum;
   logic [PHASE_W:0]   phase_sum;
   logic [PHASE_W-1:0] phase_sat, phase_in;
   logic [PHASE_W:0]   phase_diff;
   logic               step;
   logic [DATA_W-1:0]  pos_in;

   logic               dir_cur, refused, dir_in;

   assign load_sel = index_to_sel(idx_ff);
   assign in_range = (CMP_W'(idx_ff) < MOTOR_LIMIT);
   // one row address: load target or the motor being visited
   assign addr     = (mode_ff == MODE_LOAD) ? load_sel : cmd.motor;

   assign dp_status.out_free = !rsp_valid_ff || !rsp_stall;

   // velocity step, saturating
   always_comb begin
      vel_sum = {1'b0, vel_store_ff[addr]} + {1'b0, accel_store_ff[addr]};
      vel_in  = vel_sum[DATA_W] ? '1 : vel_sum[DATA_W-1:0];
   end

   // accumulator step: saturating add, then try the threshold
   always_comb begin
      phase_sum  = {1'b0, phase_store_ff[addr]} + {2'b0, vel_ff};
      phase_sat  = phase_sum[PHASE_W] ? '1 : phase_sum[PHASE_W-1:0];
      phase_diff = {1'b0, phase_sat} - {2'b0, threshold_ff};
      step       = !phase_diff[PHASE_W];
      phase_in   = step ? phase_diff[PHASE_W-1:0] : phase_sat;
      if (!step) begin
         pos_in = pos_store_ff[addr];
      end else if (dir_store_ff[addr]) begin
         pos_in = pos_store_ff[addr] + DATA_W'(1);
      end else begin
         pos_in = pos_store_ff[addr] - DATA_W'(1);
      end
   end

   // load: direction may only change while stopped
   always_comb begin
      dir_cur = dir_store_ff[addr];
      refused = (ld_dir_ff != dir_cur) && (vel_store_ff[addr] != '0);
      dir_in  = refused ? dir_cur : ld_dir_ff;
   end

   // next result
   always_comb begin
      rsp_motor_in   = rsp_motor_ff;
      rsp_stepped_in = rsp_stepped_ff;
      rsp_dir_in     = rsp_dir_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_vel_in     = rsp_vel_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;
      if (cmd.acc_step) begin
         rsp_motor_in   = sel_to_number(cmd.motor);
         rsp_stepped_in = step;
         rsp_dir_in     = dir_store_ff[addr];
         rsp_pos_in     = pos_in;
         rsp_vel_in     = vel_ff;
         rsp_status_in  = STATUS_CLEAR;
         rsp_last_in    = cmd.last;
      end else if (cmd.load_step) begin
         rsp_motor_in   = idx_ff;
         rsp_stepped_in = 1'b0;
         rsp_last_in    = 1'b1;
         if (in_range) begin
            rsp_dir_in    = dir_in;
            rsp_pos_in    = ld_pos_ff;
            rsp_vel_in    = ld_vel_ff;
            rsp_status_in = refused ? STATUS_REFUSED : STATUS_CLEAR;
         end else begin
            rsp_dir_in    = 1'b0;
            rsp_pos_in    = '0;
            rsp_vel_in    = '0;
            rsp_status_in = STATUS_CLEAR;
         end
      end
   end

   // request capture and carried velocity
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff     <= req_mode;
         idx_ff      <= req_motor_index;
         ld_vel_ff   <= req_velocity_value;
         ld_accel_ff <= req_accel_value;
         ld_pos_ff   <= req_position_value;
         ld_dir_ff   <= req_direction_value;
      end
      if (cmd.vel_step) begin
         vel_ff <= vel_in;
      end
   end

   // per-motor state and threshold
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < MOTOR_COUNT; m++) begin
            vel_store_ff[m]   <= '0;
            accel_store_ff[m] <= '0;
            phase_store_ff[m] <= '0;
            pos_store_ff[m]   <= '0;
            dir_store_ff[m]   <= 1'b0;
         end
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         if (csr_write) begin
            threshold_ff <= csr_data;
         end
         if (cmd.vel_step) begin
            vel_store_ff[addr] <= vel_in;
         end
         if (cmd.acc_step) begin
            phase_store_ff[addr] <= phase_in;
            pos_store_ff[addr]   <= pos_in;
         end
         if (cmd.load_step && in_range) begin
            vel_store_ff[addr]   <= ld_vel_ff;
            accel_store_ff[addr] <= ld_accel_ff;
            pos_store_ff[addr]   <= ld_pos_ff;
            dir_store_ff[addr]   <= dir_in;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.acc_step || cmd.load_step) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_motor_ff   <= rsp_motor_in;
      rsp_stepped_ff <= rsp_stepped_in;
      rsp_dir_ff     <= rsp_dir_in;
      rsp_pos_ff     <= rsp_pos_in;
      rsp_vel_ff     <= rsp_vel_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_motor_number  = rsp_motor_ff;
   assign rsp_stepped       = rsp_stepped_ff;
   assign rsp_direction_out = rsp_dir_ff;
   assign rsp_position_out  = rsp_pos_ff;
   assign rsp_velocity_out  = rsp_vel_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// File: hw/rtl/dda_stepper_pulse_generator_unit.sv
`timescale 1ns / 1ps

// Constant-acceleration step pulse generator for MOTOR_COUNT motors, one
// phase accumulator each. A tick transfer (req_mode = 0) visits every motor
// in turn and returns one result per motor, the final one with rsp_last set;
// a load transfer (req_mode = 1) sets one motor and returns a single result.
// Each motor takes two steps of the shared datapath (velocity update, then
// accumulate and step); the accumulate step and a load wait while the
// result side holds rsp_stall high. req_stall is low only while the
// sequencer is idle. The step threshold is written through the csr_ port
// between items.
module dda_stepper_pulse_generator_unit (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_mode,
   input  logic [dspg_pkg::INDEX_W-1:0]        req_motor_index,
   input  logic [dspg_pkg::DATA_W-1:0]         req_velocity_value,
   input  logic [dspg_pkg::DATA_W-1:0]         req_accel_value,
   input  logic signed [dspg_pkg::DATA_W-1:0]  req_position_value,
   input  logic                                req_direction_value,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [dspg_pkg::INDEX_W-1:0]        rsp_motor_number,
   output logic                                rsp_stepped,
   output logic                                rsp_direction_out,
   output logic signed [dspg_pkg::DATA_W-1:0]  rsp_position_out,
   output logic [dspg_pkg::DATA_W-1:0]         rsp_velocity_out,
   output logic                                rsp_status,
   output logic                                rsp_last,
   // step threshold write
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dspg_pkg::DATA_W-1:0]         csr_data
);
   import dspg_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;
   logic          idle;

   // sequencer: idle / load / velocity step / accumulator step
   dspg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .dp_status (dp_status),
      .cmd       (cmd),
      .idle      (idle)
   );

   // motor state, arithmetic and the result register
   dspg_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .dp_status           (dp_status),
      .req_mode            (req_mode),
      .req_motor_index     (req_motor_index),
      .req_velocity_value  (req_velocity_value),
      .req_accel_value     (req_accel_value),
      .req_position_value  (req_position_value),
      .req_direction_value (req_direction_value),
      .csr_write           (csr_valid && csr_ready),
      .csr_data            (csr_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_motor_number    (rsp_motor_number),
      .rsp_stepped         (rsp_stepped),
      .rsp_direction_out   (rsp_direction_out),
      .rsp_position_out    (rsp_position_out),
      .rsp_velocity_out    (rsp_velocity_out),
      .rsp_status          (rsp_status),
      .rsp_last            (rsp_last)
   );

   // a new request is only taken between items
   assign req_stall = !idle;
   // threshold writes land between items too
   assign csr_ready = idle;

   // a request transfer always starts a busy period
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("sequencer idle right after a request transfer");

   // a refusal can only come from a load, which is a single final result
   a_refused_is_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == STATUS_REFUSED) |-> (rsp_last && !rsp_stepped))
      else $error("refused status on a tick result");

   // no new request while results of the previous tick are still coming
   a_no_accept_mid_tick : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> req_stall)
      else $error("request taken before the tick finished");

endmodule
